// ===== design/binary_to_decimal_ascii_64_assert.svh =====
// Assertion macros used by the checker file b2d_check.sv.
`ifndef BINARY_TO_DECIMAL_ASCII_64_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_64_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define B2D_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define B2D_ASSERT_NEXT(label, cond, prop, msg) \
	`B2D_ASSERT(label, (cond) |=> (prop), msg)

`endif

// ===== design/b2d_pkg.sv =====
`timescale 1ns / 1ps

package b2d_pkg;

	localparam int VAL_W    = 64;
	localparam int DIGITS   = 20;
	localparam int DIGIT_W  = 4;
	localparam int BCD_W    = DIGITS * DIGIT_W;
	localparam int STEPS    = VAL_W;
	localparam int CNT_W    = $clog2(STEPS);
	localparam int LEFT_W   = $clog2(DIGITS + 1);
	localparam int CHAR_W   = 8;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

	localparam logic KIND_UNSIGNED = 1'b0;
	localparam logic KIND_SIGNED   = 1'b1;

	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic             neg;
	} b2d_num_t;

endpackage

// ===== design/b2d_dabble.sv =====
`timescale 1ns / 1ps

module b2d_dabble (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_kind,
	input  logic [b2d_pkg::VAL_W-1:0]   in_value,
	output logic                        num_valid,
	input  logic                        num_take,
	output b2d_pkg::b2d_num_t           num
);
	import b2d_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VAL_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic              neg_q;
	logic [BCD_W-1:0]  adj;
	logic              in_neg;
	logic              accept;

	assign in_neg    = (in_kind == KIND_SIGNED) && in_value[VAL_W-1];
	assign in_ready  = !busy_q && (!done_q || num_take);
	assign accept    = in_valid && in_ready;
	assign num_valid = done_q;
	assign num.bcd   = bcd_q;
	assign num.neg   = neg_q;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
			end else begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (done_q && num_take) begin
				done_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift one magnitude bit into the BCD digits per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= in_neg ? (VAL_W'(0) - in_value) : in_value;
			bcd_q <= '0;
			neg_q <= in_neg;
		end else if (busy_q) begin
			bin_q <= {bin_q[VAL_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[VAL_W-1]};
		end
	end

endmodule

// ===== design/b2d_emit.sv =====
`timescale 1ns / 1ps

module b2d_emit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         num_valid,
	output logic                         num_take,
	input  b2d_pkg::b2d_num_t            num,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [b2d_pkg::CHAR_W-1:0]   out_char,
	output logic                         out_last
);
	import b2d_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STRIP,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	state_t              state_q;
	logic [BCD_W-1:0]    dig_q;
	logic [LEFT_W-1:0]   left_q;
	logic                neg_q;
	logic                valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	logic                slot_free;
	logic                emit_now;
	logic [DIGIT_W-1:0]  top_digit;

	assign slot_free = !valid_q || out_ready;
	assign emit_now  = slot_free && (state_q inside {ST_SIGN, ST_DIGITS});
	assign top_digit = dig_q[BCD_W-1 -: DIGIT_W];
	assign num_take  = (state_q == ST_IDLE) && num_valid;
	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			left_q  <= '0;
			neg_q   <= 1'b0;
			dig_q   <= '0;
			char_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			if (emit_now) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (num_valid) begin
						dig_q   <= num.bcd;
						neg_q   <= num.neg;
						left_q  <= LEFT_W'(DIGITS);
						state_q <= ST_STRIP;
					end
				end
				ST_STRIP: begin
					// drop leading zeros, keep at least one digit
					if (top_digit == '0 && left_q != LEFT_W'(1)) begin
						dig_q  <= {dig_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
						left_q <= left_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_DIGITS;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						char_q  <= ASCII_MINUS;
						last_q  <= 1'b0;
						state_q <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (slot_free) begin
						char_q  <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
						last_q  <= (left_q == LEFT_W'(1));
						dig_q   <= {dig_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
						left_q  <= left_q - 1'b1;
						if (left_q == LEFT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/binary_to_decimal_ascii_64.sv =====
// An input item passes the 64 shift steps of the bit-serial double dabble unit,
// is handed on to the emitter and has its leading zeros stripped one by one
// before the first character goes out.
// Throughput: one character per cycle while m_axis_tready is high; a new item
// is taken once the dabble unit hands its digits on, while their text goes out.
// Reset (arst_n low, asynchronous) clears all control state and drops tvalid.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_64 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [b2d_pkg::VAL_W-1:0]     s_axis_tdata,  // [63:0] value
	input  logic                          s_axis_tuser,  // [0] kind
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [b2d_pkg::CHAR_W-1:0]    m_axis_tdata,  // [7:0] char_out
	output logic                          m_axis_tlast
);
	import b2d_pkg::*;

	b2d_num_t num;
	logic     num_valid;
	logic     num_take;

	b2d_dabble u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_value  (s_axis_tdata),
		.num_valid (num_valid),
		.num_take  (num_take),
		.num       (num)
	);

	b2d_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_take  (num_take),
		.num       (num),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== design/b2d_check.sv =====
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_64_assert.svh"

module b2d_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [b2d_pkg::CHAR_W-1:0]  m_axis_tdata,
	input logic                        m_axis_tlast
);
	import b2d_pkg::*;

	logic in_take;
	logic out_stall;
	logic char_ok;
	logic sign_out;

	assign in_take   = s_axis_tvalid && s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign char_ok   = (m_axis_tdata == ASCII_MINUS) ||
		(m_axis_tdata >= ASCII_ZERO && m_axis_tdata <= ASCII_NINE);
	assign sign_out  = m_axis_tvalid && (m_axis_tdata == ASCII_MINUS);

	`B2D_ASSERT_NEXT(a_in_busy, in_take, !s_axis_tready, "item taken while converting")
	`B2D_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "item dropped")
	`B2D_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled item changed")
	`B2D_ASSERT(a_char_set, m_axis_tvalid |-> char_ok, "bad character")
	`B2D_ASSERT(a_sign_not_last, sign_out |-> !m_axis_tlast, "sign flagged last")

endmodule

bind binary_to_decimal_ascii_64 b2d_check u_check (.*);

// ===== test/decimal_text_checker.sv =====
`timescale 1ns / 1ps

module decimal_text_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [b2d_pkg::VAL_W-1:0]  s_axis_tdata,   // [63:0] value
	input  logic                       s_axis_tuser,   // [0] kind
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [b2d_pkg::CHAR_W-1:0] m_axis_tdata,   // [7:0] char_out
	input  logic                       m_axis_tlast,
	output int                         mismatches,
	output int                         chars_pending
);
	import b2d_pkg::*;

	localparam logic [VAL_W-1:0] DEC_BASE = 10;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} dec_char_t;

	dec_char_t expected_chars[$];
	int        error_count;

	task automatic predict_text(input logic kind, input logic [VAL_W-1:0] value);
		logic [VAL_W-1:0]   mag;
		logic [DIGIT_W-1:0] digs [DIGITS];
		int                 nd;
		mag = value;
		nd  = 0;
		if (kind == KIND_SIGNED && value[VAL_W-1]) begin
			mag = -value;
			expected_chars.push_back('{ch: ASCII_MINUS, last: 1'b0});
		end
		do begin
			digs[nd] = DIGIT_W'(mag % DEC_BASE);
			mag      = mag / DEC_BASE;
			nd++;
		end while (mag != 0);
		for (int i = nd - 1; i >= 0; i--)
			expected_chars.push_back('{ch: ASCII_ZERO + CHAR_W'(digs[i]), last: (i == 0)});
	endtask

	always @(posedge clk) begin
		dec_char_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_text(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected item: expected none, actual char %h last %b",
						$time, m_axis_tdata, m_axis_tlast);
					error_count++;
				end else begin
					want = expected_chars.pop_front();
					if (m_axis_tdata !== want.ch) begin
						$display("%0t: char mismatch: expected %h, actual %h",
							$time, want.ch, m_axis_tdata);
						error_count++;
					end
					if (m_axis_tlast !== want.last) begin
						$display("%0t: last mismatch: expected %b, actual %b",
							$time, want.last, m_axis_tlast);
						error_count++;
					end
				end
			end
			chars_pending <= expected_chars.size();
			mismatches    <= error_count;
		end
	end

endmodule

// ===== test/tb_binary_to_decimal_ascii_64.sv =====
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_64;
	import b2d_pkg::*;

	localparam int HOLD_CYCLES      = 600;
	localparam int DRAIN_CYCLES     = 120;
	localparam int RANDOM_PER_PHASE = 19;
	localparam int PRESSURE_ITEMS   = 14;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [VAL_W-1:0]  s_axis_tdata;   // [63:0] value
	logic              s_axis_tuser;   // [0] kind
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [CHAR_W-1:0] m_axis_tdata;   // [7:0] char_out
	logic              m_axis_tlast;

	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_off;
	logic pressure_req;
	int   mismatches;
	int   chars_pending;

	binary_to_decimal_ascii_64 u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	decimal_text_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.chars_pending (chars_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(negedge clk) begin
		m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// hold the output side off so the block backs up into its input
	initial begin
		hold_off = 1'b0;
		wait (pressure_req);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	task automatic send_item(input logic kind, input logic [VAL_W-1:0] value);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		logic [VAL_W-1:0] v;
		logic [VAL_W-1:0] p;
		logic             k;
		int               sel;
		k   = $urandom_range(0, 1);
		v   = {$urandom, $urandom};
		sel = $urandom_range(0, 4);
		case (sel)
			0: ;
			1: v = v >> $urandom_range(0, VAL_W - 1);
			2: begin
				k = KIND_SIGNED;
				v = -(v >> $urandom_range(1, VAL_W - 1));
			end
			3: begin
				p = 1;
				repeat ($urandom_range(0, DIGITS - 1)) p = p * 10;
				v = p + $urandom_range(0, 2) - 1;
			end
			default: v = {1'b1, {(VAL_W - 1){1'b0}}} + $urandom_range(0, 4) - 2;
		endcase
		send_item(k, v);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_random();
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = KIND_UNSIGNED;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		pressure_req   = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		send_item(KIND_UNSIGNED, 64'd0);
		send_item(KIND_SIGNED,   64'd0);
		send_item(KIND_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(KIND_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF);
		send_item(KIND_SIGNED,   64'h8000_0000_0000_0000);
		send_item(KIND_UNSIGNED, 64'h8000_0000_0000_0000);
		send_item(KIND_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF);
		send_item(KIND_SIGNED,   64'h8000_0000_0000_0001);
		send_item(KIND_UNSIGNED, 64'd1);
		send_item(KIND_SIGNED,   64'd9);
		send_item(KIND_UNSIGNED, 64'd10);
		send_item(KIND_UNSIGNED, 64'd99);
		send_item(KIND_SIGNED,   64'd100);
		send_item(KIND_SIGNED,   -64'd10);
		send_item(KIND_UNSIGNED, 64'd10000000000000000000);
		send_item(KIND_UNSIGNED, 64'd9999999999999999999);
		send_item(KIND_UNSIGNED, 64'd12345678901234567890);
		send_item(KIND_SIGNED,   64'hAAAA_AAAA_AAAA_AAAA);
		send_item(KIND_UNSIGNED, 64'h5555_5555_5555_5555);

		run_phase(0, 0, RANDOM_PER_PHASE);
		run_phase(57, 0, RANDOM_PER_PHASE);
		run_phase(0, 57, RANDOM_PER_PHASE);
		run_phase(35, 35, RANDOM_PER_PHASE);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		pressure_req   = 1'b1;
		repeat (PRESSURE_ITEMS) send_random();
		s_axis_tvalid <= 1'b0;

		while (chars_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
